@@ design/spqv_pkg.sv @@
`timescale 1ns / 1ps
package spqv_pkg;

  localparam int unsigned MAX_SPRITES = 1024;
  localparam int unsigned INDEX_MODE  = 1;
  localparam int unsigned QUAD_IDX    = 6;
  localparam int unsigned QUAD_VTX    = 4;
  localparam int unsigned CAP         = MAX_SPRITES * QUAD_IDX;
  localparam int unsigned VTX_RES     = (INDEX_MODE == 0) ? QUAD_IDX : QUAD_VTX;
  localparam int unsigned NUM_RES     = (INDEX_MODE == 1) ? QUAD_VTX + QUAD_IDX : VTX_RES;
  localparam int unsigned VC_STEP     = VTX_RES;
  localparam int unsigned IC_STEP     = (INDEX_MODE == 0) ? 0 : QUAD_IDX;

  localparam logic [17:0] UV_MAX = 18'h3FFFF;

  localparam logic [1:0] FUNC_BEGIN  = 2'd0;
  localparam logic [1:0] FUNC_FRAME  = 2'd1;
  localparam logic [1:0] FUNC_REGION = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_INDEX  = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [2:0] REG_TILE_W  = 3'd0;
  localparam logic [2:0] REG_TILE_H  = 3'd1;
  localparam logic [2:0] REG_BORDER_X = 3'd2;
  localparam logic [2:0] REG_BORDER_Y = 3'd3;
  localparam logic [2:0] REG_PAD_X   = 3'd4;
  localparam logic [2:0] REG_PAD_Y   = 3'd5;
  localparam logic [2:0] REG_TEX_W   = 3'd6;
  localparam logic [2:0] REG_TEX_H   = 3'd7;

  // Triangle list order of the quad corners: 0,1,2,2,3,1.
  function automatic logic [1:0] quad_order(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd0: r = 2'd0;
      3'd1: r = 2'd1;
      3'd2: r = 2'd2;
      3'd3: r = 2'd2;
      3'd4: r = 2'd3;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [46:0] v);
    logic [31:0] r;
    if (v > 47'sd2147483647) r = 32'h7FFFFFFF;
    else if (v < -47'sd2147483648) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

@@ design/spqv_div.sv @@
`timescale 1ns / 1ps
module spqv_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] texel_i,
  input  logic [15:0] size_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [17:0] quot_o
);
  import spqv_pkg::*;

  // Restoring divider, one quotient bit per cycle. The quotient is known to
  // fit 18 bits whenever the texel is below four times the size.
  logic        busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] rem_q, rem_d, size_q, size_d;
  logic [17:0] low_q, low_d, quot_q, quot_d;
  logic [16:0] trial;
  logic        sat;

  assign sat   = (size_i == 16'd0) || (texel_i >= {14'd0, size_i, 2'd0});
  assign trial = {rem_q, low_q[17]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    size_d = size_q;
    low_d  = low_q;
    quot_d = quot_q;
    if (start_i) begin
      size_d = size_i;
      if (sat) begin
        quot_d = UV_MAX;
        done_d = 1'b1;
      end else begin
        rem_d  = texel_i[17:2];
        low_d  = {texel_i[1:0], 16'd0};
        quot_d = 18'd0;
        cnt_d  = 5'd18;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (trial >= {1'b0, size_q}) begin
        rem_d  = 16'(trial - {1'b0, size_q});
        quot_d = {quot_q[16:0], 1'b1};
      end else begin
        rem_d  = trial[15:0];
        quot_d = {quot_q[16:0], 1'b0};
      end
      low_d = {low_q[16:0], 1'b0};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    size_q <= size_d;
    low_q  <= low_d;
    quot_q <= quot_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> !done_q)
    else $error("divider done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> cnt_q != 5'd0)
    else $error("divider busy with empty count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == 5'd1) |=> done_q)
    else $error("divider missed its done pulse");
endmodule

@@ design/sprite_quad_vertex_generator_unit.sv @@
`timescale 1ns / 1ps
// A sprite takes four products on the multiplier, an edge step and four divisions
// in turn on the one shared divider (shorter when u or v saturates), then one
// result word per cycle while the output is not stalled, ten for an indexed quad.
// Requests are taken one at a time; begin and ignored requests emit no word and
// a rejected request only a reject word. Reset clears the batch state, the counts and the
// configuration to 16x16 tiles, no border or padding, a 256x256 texture.
module sprite_quad_vertex_generator_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata, from bit 0: src_x, src_y, src_width, src_height, center_x, center_y,
  // extent_x, extent_y, depth, flip, color, zero fill.
  input  logic [263:0] s_axis_tdata,
  // tuser: func.
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata, from bit 0: slot, pos_x, pos_y, pos_z, tex_u, tex_v, vertex_color,
  // index_value, zero fill.
  output logic [191:0] m_axis_tdata,
  // tuser: kind.
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  import spqv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_EDGE, S_DIV, S_DWAIT, S_EMIT
  } state_e;

  // Configuration registers.
  logic [12:0] tile_w_q, tile_h_q;
  logic [11:0] border_x_q, border_y_q, pad_x_q, pad_y_q;
  logic [15:0] tex_w_q, tex_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_w_q   <= 13'd16;
      tile_h_q   <= 13'd16;
      border_x_q <= 12'd0;
      border_y_q <= 12'd0;
      pad_x_q    <= 12'd0;
      pad_y_q    <= 12'd0;
      tex_w_q    <= 16'd256;
      tex_h_q    <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TILE_W:   tile_w_q   <= cfg_data_i[12:0];
        REG_TILE_H:   tile_h_q   <= cfg_data_i[12:0];
        REG_BORDER_X: border_x_q <= cfg_data_i[11:0];
        REG_BORDER_Y: border_y_q <= cfg_data_i[11:0];
        REG_PAD_X:    pad_x_q    <= cfg_data_i[11:0];
        REG_PAD_Y:    pad_y_q    <= cfg_data_i[11:0];
        REG_TEX_W:    tex_w_q    <= cfg_data_i;
        REG_TEX_H:    tex_h_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e      state_q;
  logic [3:0]  step_q;
  logic        open_q, rej_q;
  logic [12:0] vc_q, ic_q;

  // Captured request word.
  logic [1:0]  func_q, flip_q;
  logic [15:0] sx_q, sy_q, sw_q, sh_q;
  logic [31:0] cx_q, cy_q, ex_q, ey_q, z_q, color_q;

  // Products of the shared multiplier, edges, texels and uv results.
  logic signed [49:0] prod_q [4];
  logic [31:0] xl_q, xr_q, yt_q, yb_q;
  logic [31:0] texel_q [4];
  logic [17:0] uv_q [4];

  // Output register.
  logic         ovalid_q, olast_q;
  logic [1:0]   okind_q;
  logic [191:0] odata_q;

  logic accept, func_begin, full, out_free, emit_fire;
  logic [12:0] chk_cnt;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign func_begin    = (s_axis_tuser == FUNC_BEGIN);
  assign chk_cnt       = (INDEX_MODE != 0) ? ic_q : vc_q;
  assign full          = ({1'b0, chk_cnt} + 14'(QUAD_IDX)) > 14'(CAP);
  assign out_free      = !ovalid_q || m_axis_tready;
  assign emit_fire     = (state_q == S_EMIT) && out_free;

  // Multiplier operand selection, one product per cycle.
  logic signed [16:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [49:0] mul_p;

  always_comb begin
    case (step_q[1:0])
      2'd0: begin
        mul_a = $signed({4'd0, tile_w_q});
        mul_b = $signed({ex_q[31], ex_q});
      end
      2'd1: begin
        mul_a = $signed({4'd0, tile_h_q});
        mul_b = $signed({ey_q[31], ey_q});
      end
      2'd2: begin
        mul_a = $signed({1'b0, sx_q});
        mul_b = $signed({19'd0, 14'({1'b0, tile_w_q} + {2'd0, pad_x_q})});
      end
      default: begin
        mul_a = $signed({1'b0, sy_q});
        mul_b = $signed({19'd0, 14'({1'b0, tile_h_q} + {2'd0, pad_y_q})});
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Half extents and edges. Frame halves round toward minus infinity, region
  // halves are truncated toward zero to whole pixels.
  logic signed [46:0] hx, hy, sxl, sxr, syt, syb;
  logic signed [32:0] rx, ry;
  logic [31:0] tl, tr, tt, tb;

  always_comb begin
    rx = ($signed({ex_q[31], ex_q}) + (ex_q[31] ? 33'sd131071 : 33'sd0)) >>> 17;
    ry = ($signed({ey_q[31], ey_q}) + (ey_q[31] ? 33'sd131071 : 33'sd0)) >>> 17;
    if (func_q == FUNC_FRAME) begin
      hx = 47'(prod_q[0] >>> 1);
      hy = 47'(prod_q[1] >>> 1);
      tl = 32'({1'b0, border_x_q} + 31'(prod_q[2][29:0]));
      tt = 32'({1'b0, border_y_q} + 31'(prod_q[3][29:0]));
      tr = tl + {19'd0, tile_w_q};
      tb = tt + {19'd0, tile_h_q};
    end else begin
      hx = {{14{rx[32]}}, rx} <<< 16;
      hy = {{14{ry[32]}}, ry} <<< 16;
      tl = {16'd0, sx_q};
      tt = {16'd0, sy_q};
      tr = 32'({1'b0, sx_q} + {1'b0, sw_q});
      tb = 32'({1'b0, sy_q} + {1'b0, sh_q});
    end
    sxl = $signed({{15{cx_q[31]}}, cx_q}) - hx;
    sxr = $signed({{15{cx_q[31]}}, cx_q}) + hx;
    syt = $signed({{15{cy_q[31]}}, cy_q}) - hy;
    syb = $signed({{15{cy_q[31]}}, cy_q}) + hy;
  end

  // Shared divider: u left, u right, v top, v bottom in turn.
  logic        div_start, div_busy, div_done;
  logic [17:0] div_quot;

  assign div_start = (state_q == S_DIV);

  spqv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .texel_i (texel_q[step_q[1:0]]),
    .size_i  (step_q[1] ? tex_h_q : tex_w_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Result word for the current emit step.
  logic [17:0] ul, ur, vt, vb;
  logic [1:0]  vsel;
  logic [2:0]  ik;
  logic        is_vtx, is_last;
  logic [1:0]  w_kind;
  logic [191:0] w_data;

  always_comb begin
    ul = flip_q[0] ? uv_q[1] : uv_q[0];
    ur = flip_q[0] ? uv_q[0] : uv_q[1];
    vt = flip_q[1] ? uv_q[3] : uv_q[2];
    vb = flip_q[1] ? uv_q[2] : uv_q[3];
    is_vtx  = (step_q < 4'(VTX_RES));
    is_last = rej_q || (step_q == 4'(NUM_RES - 1));
    vsel    = (INDEX_MODE == 0) ? quad_order(step_q[2:0]) : step_q[1:0];
    ik      = 3'(step_q - 4'(VTX_RES));
    w_data  = '0;
    if (rej_q) begin
      w_kind = KIND_REJECT;
    end else if (is_vtx) begin
      w_kind          = KIND_VERTEX;
      w_data[12:0]    = vc_q + {9'd0, step_q};
      w_data[44:13]   = vsel[0] ? xr_q : xl_q;
      w_data[76:45]   = vsel[1] ? yb_q : yt_q;
      w_data[108:77]  = z_q;
      w_data[126:109] = vsel[0] ? ur : ul;
      w_data[144:127] = vsel[1] ? vb : vt;
      w_data[176:145] = color_q;
    end else begin
      w_kind          = KIND_INDEX;
      w_data[12:0]    = ic_q + {10'd0, ik};
      w_data[189:177] = vc_q + {11'd0, quad_order(ik)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= 4'd0;
      open_q   <= 1'b0;
      rej_q    <= 1'b0;
      vc_q     <= 13'd0;
      ic_q     <= 13'd0;
      ovalid_q <= 1'b0;
      okind_q  <= KIND_VERTEX;
      olast_q  <= 1'b0;
    end else begin
      // The output register loads a new word or drains once it is taken.
      if (emit_fire) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            step_q <= 4'd0;
            if (func_begin) begin
              open_q <= 1'b1;
              vc_q   <= 13'd0;
              ic_q   <= 13'd0;
            end else if (s_axis_tuser != FUNC_NONE) begin
              rej_q   <= !open_q || full;
              state_q <= (!open_q || full) ? S_EMIT : S_MUL;
            end
          end
        end
        S_MUL: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd3) begin
            state_q <= S_EDGE;
          end
        end
        S_EDGE: begin
          step_q  <= 4'd0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          state_q <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            if (step_q == 4'd3) begin
              step_q  <= 4'd0;
              state_q <= S_EMIT;
            end else begin
              step_q  <= step_q + 4'd1;
              state_q <= S_DIV;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            okind_q  <= w_kind;
            olast_q  <= is_last;
            step_q   <= step_q + 4'd1;
            if (is_last) begin
              state_q <= S_IDLE;
              rej_q   <= 1'b0;
              if (!rej_q) begin
                vc_q <= vc_q + 13'(VC_STEP);
                ic_q <= ic_q + 13'(IC_STEP);
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= s_axis_tuser;
      sx_q    <= s_axis_tdata[15:0];
      sy_q    <= s_axis_tdata[31:16];
      sw_q    <= s_axis_tdata[47:32];
      sh_q    <= s_axis_tdata[63:48];
      cx_q    <= s_axis_tdata[95:64];
      cy_q    <= s_axis_tdata[127:96];
      ex_q    <= s_axis_tdata[159:128];
      ey_q    <= s_axis_tdata[191:160];
      z_q     <= s_axis_tdata[223:192];
      flip_q  <= s_axis_tdata[225:224];
      color_q <= s_axis_tdata[257:226];
    end
    if (state_q == S_MUL) prod_q[step_q[1:0]] <= mul_p;
    if (state_q == S_EDGE) begin
      xl_q       <= clamp32(sxl);
      xr_q       <= clamp32(sxr);
      yt_q       <= clamp32(syt);
      yb_q       <= clamp32(syb);
      texel_q[0] <= tl;
      texel_q[1] <= tr;
      texel_q[2] <= tt;
      texel_q[3] <= tb;
    end
    if (state_q == S_DWAIT && div_done) uv_q[step_q[1:0]] <= div_quot;
    if (emit_fire) odata_q <= w_data;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && okind_q == KIND_REJECT) |-> olast_q)
    else $error("reject word without last");
  assert property (@(posedge clk_i) disable iff (!rst_ni) ic_q <= 13'(CAP))
    else $error("index count beyond capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni) s_axis_tready |-> !div_busy)
    else $error("ready while divider busy");
endmodule

@@ tb/sv/sprite_quad_vertex_generator_unit_tb.sv @@
`timescale 1ns / 1ps
module sprite_quad_vertex_generator_unit_tb;
  import spqv_pkg::*;

  // One sprite request as it travels on the slave side.
  typedef struct {
    logic [1:0]  func;
    logic [15:0] sx, sy, sw, sh;
    logic [31:0] cx, cy, ex, ey, z;
    logic [1:0]  flip;
    logic [31:0] color;
  } sprite_req_t;

  // One word of the batch buffer stream.
  typedef struct {
    logic [1:0]  kind;
    logic [12:0] slot;
    logic [31:0] px, py, pz;
    logic [17:0] u, v;
    logic [31:0] col;
    logic [12:0] idx;
    logic        last;
  } buf_word_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_index_i = '0;
  logic [15:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // tdata, from bit 0: src_x, src_y, src_width, src_height, center_x, center_y,
  // extent_x, extent_y, depth, flip, color, zero fill.
  logic [263:0] s_axis_tdata = '0;
  // tuser: func.
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // tdata, from bit 0: slot, pos_x, pos_y, pos_z, tex_u, tex_v, vertex_color,
  // index_value, zero fill.
  logic [191:0] m_axis_tdata;
  // tuser: kind.
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  sprite_quad_vertex_generator_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Mirror of the configuration registers, kept at their reset values until
  // a write goes to the block.
  logic [12:0] tile_w = 13'd16, tile_h = 13'd16;
  logic [11:0] bord_x = '0, bord_y = '0, pad_x = '0, pad_y = '0;
  logic [15:0] tex_w = 16'd256, tex_h = 16'd256;

  // Mirror of the batch state.
  logic        batch_is_open = 1'b0;
  logic [12:0] vtx_count = '0, idx_count = '0;

  sprite_req_t sprite_q[$];
  buf_word_t   word_q[$];
  int          max_src_gap = 6;
  int          max_sink_stall = 6;
  int          n_mismatch = 0;
  int          n_words = 0;
  int          n_requests = 0;
  int          n_rejects = 0;

  function automatic longint sat32(longint val);
    if (val > 64'sd2147483647) return 64'sd2147483647;
    if (val < -64'sd2147483648) return -64'sd2147483648;
    return val;
  endfunction

  function automatic logic [17:0] texel_to_uv(longint texel, logic [15:0] size);
    longint q;
    if (size == 0) return UV_MAX;
    q = (texel << 16) / longint'(size);
    return (q > 262143) ? UV_MAX : q[17:0];
  endfunction

  // Works out the words that one accepted request puts in the batch buffer
  // and advances the batch state the same way the block does.
  task automatic predict_sprite(input sprite_req_t r);
    longint    cxl, cyl, exl, eyl, p, hx, hy, tl, tr, tt, tb;
    logic [31:0] xl, xr, yt, yb;
    logic [17:0] ul, ur, vt, vb, t;
    logic [31:0] cx4[4], cy4[4];
    logic [17:0] cu4[4], cv4[4];
    int        ord[6];
    buf_word_t w;
    logic [12:0] base;
    int        nres;
    ord = '{0, 1, 2, 2, 3, 1};
    if (r.func == FUNC_BEGIN) begin
      batch_is_open = 1'b1;
      vtx_count = '0;
      idx_count = '0;
      return;
    end
    if (r.func == FUNC_NONE) return;
    w = '{kind: KIND_REJECT, slot: '0, px: '0, py: '0, pz: '0, u: '0, v: '0,
          col: '0, idx: '0, last: 1'b1};
    if (!batch_is_open ||
        (INDEX_MODE != 0 && int'(idx_count) + QUAD_IDX > CAP) ||
        (INDEX_MODE == 0 && int'(vtx_count) + QUAD_IDX > CAP)) begin
      word_q.push_back(w);
      n_rejects++;
      return;
    end
    cxl = longint'($signed(r.cx));
    cyl = longint'($signed(r.cy));
    exl = longint'($signed(r.ex));
    eyl = longint'($signed(r.ey));
    if (r.func == FUNC_FRAME) begin
      // Half extent of a frame rounds toward minus infinity.
      p = longint'(tile_w) * exl;
      hx = (p >= 0) ? p / 2 : -((-p + 1) / 2);
      p = longint'(tile_h) * eyl;
      hy = (p >= 0) ? p / 2 : -((-p + 1) / 2);
      tl = longint'(bord_x) + longint'(r.sx) * (longint'(tile_w) + longint'(pad_x));
      tr = tl + longint'(tile_w);
      tt = longint'(bord_y) + longint'(r.sy) * (longint'(tile_h) + longint'(pad_y));
      tb = tt + longint'(tile_h);
    end else begin
      // A region keeps only whole pixels of its half size.
      hx = (exl / 131072) * 65536;
      hy = (eyl / 131072) * 65536;
      tl = longint'(r.sx);
      tr = tl + longint'(r.sw);
      tt = longint'(r.sy);
      tb = tt + longint'(r.sh);
    end
    xl = sat32(cxl - hx);
    xr = sat32(cxl + hx);
    yt = sat32(cyl - hy);
    yb = sat32(cyl + hy);
    ul = texel_to_uv(tl, tex_w);
    ur = texel_to_uv(tr, tex_w);
    vt = texel_to_uv(tt, tex_h);
    vb = texel_to_uv(tb, tex_h);
    if (r.flip[0]) begin t = ul; ul = ur; ur = t; end
    if (r.flip[1]) begin t = vt; vt = vb; vb = t; end
    cx4 = '{xl, xr, xl, xr};
    cy4 = '{yt, yt, yb, yb};
    cu4 = '{ul, ur, ul, ur};
    cv4 = '{vt, vt, vb, vb};
    base = vtx_count;
    nres = (INDEX_MODE == 1) ? QUAD_VTX + QUAD_IDX : ((INDEX_MODE == 0) ? QUAD_IDX : QUAD_VTX);
    if (INDEX_MODE != 0) begin
      for (int k = 0; k < QUAD_VTX; k++) begin
        w = '{kind: KIND_VERTEX, slot: base + k, px: cx4[k], py: cy4[k], pz: r.z,
              u: cu4[k], v: cv4[k], col: r.color, idx: '0, last: (k == nres - 1)};
        word_q.push_back(w);
      end
      if (INDEX_MODE != 2) begin
        for (int k = 0; k < QUAD_IDX; k++) begin
          w = '{kind: KIND_INDEX, slot: idx_count + k, px: '0, py: '0, pz: '0,
                u: '0, v: '0, col: '0, idx: base + ord[k], last: (k == QUAD_IDX - 1)};
          word_q.push_back(w);
        end
      end
      vtx_count = vtx_count + QUAD_VTX;
      idx_count = idx_count + QUAD_IDX;
    end else begin
      for (int k = 0; k < QUAD_IDX; k++) begin
        w = '{kind: KIND_VERTEX, slot: base + k, px: cx4[ord[k]], py: cy4[ord[k]],
              pz: r.z, u: cu4[ord[k]], v: cv4[ord[k]], col: r.color, idx: '0,
              last: (k == QUAD_IDX - 1)};
        word_q.push_back(w);
      end
      vtx_count = vtx_count + QUAD_IDX;
    end
  endtask

  // Slave side: one request in flight, with a random gap before each one.
  sprite_req_t cur_req;
  int          src_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_sprite(cur_req);
        n_requests++;
        src_gap = $urandom_range(0, max_src_gap);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (sprite_q.size() > 0) begin
          cur_req = sprite_q.pop_front();
          s_axis_tdata <= {6'b0, cur_req.color, cur_req.flip, cur_req.z, cur_req.ey,
                           cur_req.ex, cur_req.cy, cur_req.cx, cur_req.sh, cur_req.sw,
                           cur_req.sy, cur_req.sx};
          s_axis_tuser <= cur_req.func;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Master side: every word is checked against the oldest expectation, and
  // the ready line is dropped for a random number of cycles after each word.
  int sink_stall = 0;
  always @(posedge clk_i) begin
    buf_word_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{kind: m_axis_tuser, slot: m_axis_tdata[12:0], px: m_axis_tdata[44:13],
                py: m_axis_tdata[76:45], pz: m_axis_tdata[108:77],
                u: m_axis_tdata[126:109], v: m_axis_tdata[144:127],
                col: m_axis_tdata[176:145], idx: m_axis_tdata[189:177],
                last: m_axis_tlast};
        n_words++;
        if (word_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("%0t: unexpected word kind %0d slot %0d", $realtime, got.kind,
                     got.slot);
        end else begin
          want = word_q.pop_front();
          if (got.kind !== want.kind || got.slot !== want.slot || got.px !== want.px ||
              got.py !== want.py || got.pz !== want.pz || got.u !== want.u ||
              got.v !== want.v || got.col !== want.col || got.idx !== want.idx ||
              got.last !== want.last) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("%0t: word mismatch", $realtime);
              $display("  exp kind %0d slot %0d x %h y %h z %h u %h v %h col %h idx %0d last %b",
                       want.kind, want.slot, want.px, want.py, want.pz, want.u, want.v,
                       want.col, want.idx, want.last);
              $display("  got kind %0d slot %0d x %h y %h z %h u %h v %h col %h idx %0d last %b",
                       got.kind, got.slot, got.px, got.py, got.pz, got.u, got.v,
                       got.col, got.idx, got.last);
            end
          end
        end
        sink_stall = $urandom_range(0, max_sink_stall);
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic sprite_req_t mk_req(logic [1:0] f, logic [15:0] sx, logic [15:0] sy,
                                         logic [15:0] sw, logic [15:0] sh, logic [31:0] cx,
                                         logic [31:0] cy, logic [31:0] ex, logic [31:0] ey,
                                         logic [1:0] fl);
    sprite_req_t r;
    r = '{func: f, sx: sx, sy: sy, sw: sw, sh: sh, cx: cx, cy: cy, ex: ex, ey: ey,
          z: $urandom, flip: fl, color: $urandom};
    return r;
  endfunction

  // Random request: mostly frames and regions with small extents, now and
  // then a new batch, an ignored code or full-range operands.
  function automatic sprite_req_t rand_req();
    sprite_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.func = (pick < 5) ? FUNC_BEGIN : (pick < 8) ? FUNC_NONE :
             (pick < 54) ? FUNC_FRAME : FUNC_REGION;
    r.sx = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40);
    r.sy = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40);
    r.sw = $urandom;
    r.sh = $urandom;
    r.cx = $urandom;
    r.cy = $urandom;
    r.ex = ($urandom_range(0, 2) == 0) ? $urandom : 32'($signed($urandom_range(0, 1 << 22)) -
                                                        (1 << 20));
    r.ey = ($urandom_range(0, 2) == 0) ? $urandom : 32'($signed($urandom_range(0, 1 << 22)) -
                                                        (1 << 20));
    r.z = $urandom;
    r.flip = $urandom_range(0, 3);
    r.color = $urandom;
    return r;
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (sprite_q.size() > 0 || s_axis_tvalid || word_q.size() > 0);
    // Begin and ignored requests leave no word, so give the block time to finish.
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_TILE_W:   tile_w = val[12:0];
      REG_TILE_H:   tile_h = val[12:0];
      REG_BORDER_X: bord_x = val[11:0];
      REG_BORDER_Y: bord_y = val[11:0];
      REG_PAD_X:    pad_x = val[11:0];
      REG_PAD_Y:    pad_y = val[11:0];
      REG_TEX_W:    tex_w = val;
      default:      tex_h = val;
    endcase
  endtask

  task automatic set_atlas(int tw, int th, int bx, int by, int px, int py, int xw, int xh);
    write_reg(REG_TILE_W, tw);
    write_reg(REG_TILE_H, th);
    write_reg(REG_BORDER_X, bx);
    write_reg(REG_BORDER_Y, by);
    write_reg(REG_PAD_X, px);
    write_reg(REG_PAD_Y, py);
    write_reg(REG_TEX_W, xw);
    write_reg(REG_TEX_H, xh);
  endtask

  task automatic run_random(int n);
    sprite_q.push_back(mk_req(FUNC_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    repeat (n) sprite_q.push_back(rand_req());
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset configuration. A frame before any begin is
    // rejected because no batch is open.
    sprite_q.push_back(mk_req(FUNC_FRAME, 1, 1, 0, 0, 0, 0, 32'h10000, 32'h10000, 0));
    sprite_q.push_back(mk_req(FUNC_NONE, 3, 3, 3, 3, 0, 0, 0, 0, 0));
    sprite_q.push_back(mk_req(FUNC_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    for (int f = 0; f < 4; f++) begin
      sprite_q.push_back(mk_req(FUNC_FRAME, f, 2, 0, 0, 32'h00640000, 32'h00320000,
                                32'h00018000, 32'h00020000, f));
      sprite_q.push_back(mk_req(FUNC_REGION, 16, 32, 48, 64, 32'h00100000, 32'h00200000,
                                32'h00130000, 32'h000F8000, f));
    end
    // Saturating edges, negative extents and region truncation of odd sizes.
    sprite_q.push_back(mk_req(FUNC_FRAME, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000,
                              32'h7FFFFFFF, 32'h7FFFFFFF, 0));
    sprite_q.push_back(mk_req(FUNC_FRAME, 1, 1, 0, 0, 32'h80000000, 32'h7FFFFFFF,
                              32'h80000000, 32'hFFFFFFFF, 3));
    sprite_q.push_back(mk_req(FUNC_REGION, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000,
                              32'h80000000, 32'h7FFFFFFF, 1));
    sprite_q.push_back(mk_req(FUNC_REGION, 5, 7, 3, 1, 0, 0, 32'hFFFEFFFF, 32'h0001FFFF, 2));
    // Texel indexes at the top of their range saturate u and v.
    sprite_q.push_back(mk_req(FUNC_FRAME, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0,
                              32'h10000, 32'h10000, 0));
    sprite_q.push_back(mk_req(FUNC_REGION, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0,
                              32'h10000, 32'h10000, 3));
    // Begin while the batch is open starts over with zero counts.
    sprite_q.push_back(mk_req(FUNC_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    sprite_q.push_back(mk_req(FUNC_FRAME, 2, 3, 0, 0, 32'hFFF00000, 32'h00080000,
                              32'h00004000, 32'hFFFF8000, 0));
    wait_idle();

    // Smallest tiles, largest borders and padding, extreme texture sizes.
    set_atlas(1, 1, 4095, 4095, 4095, 4095, 1, 65535);
    run_random(85);
    wait_idle();

    // Large tiles of the tallest height, no border or padding, zero texture width.
    max_src_gap = 0;
    set_atlas(4096, 8191, 0, 0, 0, 0, 0, 65535);
    run_random(85);
    wait_idle();

    // Mid-range atlas with back-to-back traffic on both sides.
    max_sink_stall = 0;
    set_atlas($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(0, 4095),
              $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
              $urandom_range(1, 65535), 0);
    run_random(85);
    wait_idle();

    max_src_gap = 6;
    max_sink_stall = 6;
    set_atlas(16, 16, 0, 0, 0, 0, 256, 256);
    run_random(85);
    wait_idle();

    $display("Covered %0d requests, %0d buffer words and %0d rejects", n_requests,
             n_words, n_rejects);
    $display("over five atlas settings; %0d mismatches", n_mismatch);
    if (n_mismatch == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d words still expected", word_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
design/spqv_pkg.sv
design/spqv_div.sv
design/sprite_quad_vertex_generator_unit.sv
tb/sv/sprite_quad_vertex_generator_unit_tb.sv
